@@ rtl/uart_to_sram_dma_channel_assert.svh @@
// Assertion macros for the UART to SRAM DMA channel.
// Used by the port checker; needs a clock named clock and a reset named reset in scope.
`ifndef UART_TO_SRAM_DMA_CHANNEL_ASSERT_SVH
`define UART_TO_SRAM_DMA_CHANNEL_ASSERT_SVH

// Checked outside reset only.
`define UDMA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define UDMA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/udma_pkg.sv @@
// Shared constants, codes and item types of the UART to SRAM DMA channel.
// Used by the engine, the top level and the port checker.
`default_nettype none

package udma_pkg;

   localparam int unsigned WORD_W       = 32;
   localparam int unsigned STATUS_W     = 2;
   localparam int unsigned CMD_W        = 2;
   localparam int unsigned REG_INDEX_W  = 3;
   localparam int unsigned SRAM_WORDS_W = 31;
   localparam int unsigned CSR_INDEX_W  = 1;
   localparam int unsigned CSR_DATA_W   = 31;
   localparam int unsigned SEGMENT_W    = 2;
   localparam int unsigned SEG_SHIFT    = 30;

   // Stream widths: fields packed from bit 0 up, padded to whole bytes
   localparam int unsigned REQ_TDATA_W = 72;
   localparam int unsigned REQ_TUSER_W = CMD_W;
   localparam int unsigned RSP_TDATA_W = 104;

   // Item kinds
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

   // Bus register indexes
   localparam logic [REG_INDEX_W-1:0] REG_ACTIVE = 3'd0;
   localparam logic [REG_INDEX_W-1:0] REG_SOURCE = 3'd1;
   localparam logic [REG_INDEX_W-1:0] REG_DEST   = 3'd2;
   localparam logic [REG_INDEX_W-1:0] REG_COUNT  = 3'd3;
   localparam logic [REG_INDEX_W-1:0] REG_STATUS = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_IDLE     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BUSY     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_COMPLETE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ERROR    = 2'd3;

   // Configuration register indexes and reset values
   localparam logic [CSR_INDEX_W-1:0]  CSR_ACTIVE_AT_RESET     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0]  CSR_SRAM_WORDS          = 1'd1;
   localparam logic                    ACTIVE_AT_RESET_DEFAULT = 1'b0;
   localparam logic [SRAM_WORDS_W-1:0] SRAM_WORDS_DEFAULT      = 31'd65536;

   // Address map segments
   localparam logic [SEGMENT_W-1:0] UART_SEGMENT = 2'd1;
   localparam logic [SEGMENT_W-1:0] SRAM_SEGMENT = 2'd2;
   localparam logic [WORD_W-1:0]    UART_RX_ADDR = {UART_SEGMENT, 30'd1};

   typedef struct packed {
      logic [CMD_W-1:0]       cmd;
      logic [REG_INDEX_W-1:0] reg_index;
      logic [WORD_W-1:0]      write_value;
      logic                   uart_word_valid;
      logic [WORD_W-1:0]      uart_word;
   } req_item_type;

   typedef struct packed {
      logic [WORD_W-1:0]   read_data;
      logic                store_valid;
      logic [WORD_W-1:0]   store_address;
      logic [WORD_W-1:0]   store_data;
      logic                irq_pending;
      logic [STATUS_W-1:0] status_now;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ rtl/udma_engine.sv @@
// DMA channel register file and per-item step logic.
// Depends on udma_pkg for codes and item types.
`default_nettype none

module udma_engine (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 item_fire,
   input  wire udma_pkg::req_item_type               item,
   input  wire logic                                 active_reset_value,
   input  wire logic [udma_pkg::SRAM_WORDS_W-1:0]    sram_words,
   output udma_pkg::rsp_item_type                    result
);

   logic                              active_ff, active_in;
   logic [udma_pkg::WORD_W-1:0]       source_ff, source_in;
   logic [udma_pkg::WORD_W-1:0]       dest_ff, dest_in;
   logic [udma_pkg::WORD_W-1:0]       total_ff, total_in;
   logic [udma_pkg::WORD_W-1:0]       done_ff, done_in;
   logic [udma_pkg::STATUS_W-1:0]     status_ff, status_in;
   logic                              irq_ff, irq_in;

   logic [udma_pkg::SRAM_WORDS_W-1:0] dest_index;
   logic [udma_pkg::SRAM_WORDS_W-1:0] room;
   logic                              config_ok;
   logic [udma_pkg::WORD_W-1:0]       done_inc;
   logic                              write_allowed;

   // Start check: source is the UART port, destination segment is at or above the SRAM segment and fits
   assign dest_index = dest_ff[udma_pkg::SRAM_WORDS_W-1:0];
   assign room       = sram_words - dest_index;
   assign config_ok  = (source_ff == udma_pkg::UART_RX_ADDR)
                     && (dest_ff[udma_pkg::WORD_W-1 -: udma_pkg::SEGMENT_W]
                         >= udma_pkg::SRAM_SEGMENT)
                     && (dest_index <= sram_words)
                     && (total_ff <= {1'b0, room});

   assign done_inc      = done_ff + 32'd1;
   assign write_allowed = active_ff
                        && !(status_ff == udma_pkg::ST_BUSY
                             && item.reg_index != udma_pkg::REG_STATUS);

   always_comb begin
      active_in = active_ff;
      source_in = source_ff;
      dest_in   = dest_ff;
      total_in  = total_ff;
      done_in   = done_ff;
      status_in = status_ff;
      irq_in    = irq_ff;

      result = '0;

      case (item.cmd)
         udma_pkg::CMD_READ: begin
            if (item.reg_index == udma_pkg::REG_ACTIVE) begin
               result.read_data = {31'd0, active_ff};
            end else if (active_ff) begin
               case (item.reg_index)
                  udma_pkg::REG_SOURCE: result.read_data = source_ff;
                  udma_pkg::REG_DEST:   result.read_data = dest_ff;
                  udma_pkg::REG_COUNT:  result.read_data = total_ff;
                  udma_pkg::REG_STATUS: result.read_data = {30'd0, status_ff};
                  default:              result.read_data = '0;
               endcase
            end
         end
         udma_pkg::CMD_WRITE: begin
            if (item.reg_index == udma_pkg::REG_ACTIVE) begin
               active_in = (item.write_value != '0);
               if (item.write_value == '0) begin
                  status_in = udma_pkg::ST_IDLE;
                  irq_in    = 1'b0;
               end
            end else if (write_allowed) begin
               case (item.reg_index)
                  udma_pkg::REG_SOURCE: source_in = item.write_value;
                  udma_pkg::REG_DEST:   dest_in   = item.write_value;
                  udma_pkg::REG_COUNT:  total_in  = item.write_value;
                  udma_pkg::REG_STATUS: begin
                     if (item.write_value == {30'd0, udma_pkg::ST_BUSY}) begin
                        // Restart: clear progress, then check and launch
                        done_in = '0;
                        irq_in  = 1'b0;
                        if (!config_ok) begin
                           status_in = udma_pkg::ST_ERROR;
                           irq_in    = 1'b1;
                        end else if (total_ff == '0) begin
                           status_in = udma_pkg::ST_COMPLETE;
                           irq_in    = 1'b1;
                        end else begin
                           status_in = udma_pkg::ST_BUSY;
                        end
                     end else if (item.write_value == {30'd0, udma_pkg::ST_IDLE}) begin
                        status_in = udma_pkg::ST_IDLE;
                        irq_in    = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         udma_pkg::CMD_TICK: begin
            if (status_ff == udma_pkg::ST_BUSY) begin
               if (!item.uart_word_valid) begin
                  status_in = udma_pkg::ST_ERROR;
                  irq_in    = 1'b1;
               end else begin
                  result.store_valid   = 1'b1;
                  result.store_address = dest_ff + done_ff;
                  result.store_data    = item.uart_word;
                  done_in              = done_inc;
                  if (done_inc == total_ff) begin
                     status_in = udma_pkg::ST_COMPLETE;
                     irq_in    = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase

      result.irq_pending = irq_in;
      result.status_now  = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= active_reset_value;
         source_ff <= '0;
         dest_ff   <= '0;
         total_ff  <= '0;
         done_ff   <= '0;
         status_ff <= udma_pkg::ST_IDLE;
         irq_ff    <= 1'b0;
      end else if (item_fire) begin
         active_ff <= active_in;
         source_ff <= source_in;
         dest_ff   <= dest_in;
         total_ff  <= total_in;
         done_ff   <= done_in;
         status_ff <= status_in;
         irq_ff    <= irq_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/uart_to_sram_dma_channel.sv @@
// Top level of the UART to SRAM DMA channel: stream ports, input and result
// registers, configuration registers. Depends on udma_pkg and udma_engine.
//
//   channel   direction  ports               moves
//   req       in         req_t*              one bus read, bus write or tick per item
//   rsp       out        rsp_t*              one result per item
//   csr       in         csr_wen/index/wdata configuration write, no wait
//
// One item per cycle sustained while rsp is not stalled; an item passes from req through
// the input register and the engine step into the result register, then onto rsp.
// The engine register file updates as the item leaves the input register.
// A stalled rsp holds the result; req keeps accepting while the input register
// can drain in the same cycle.
// Reset is synchronous; both registers empty and the engine state clears.
// req_tready stays low while reset is high.
`default_nettype none

module uart_to_sram_dma_channel (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // reg_index[2:0], write_value[34:3], uart_word_valid[35], uart_word[67:36]
   input  wire logic [udma_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // cmd[1:0]
   input  wire logic [udma_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // read_data[31:0], store_valid[32], store_address[64:33], store_data[96:65],
   // irq_pending[97], status_now[99:98]
   output      logic [udma_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  wire logic                                csr_wen,
   input  wire logic [udma_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [udma_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic                                active_at_reset_ff, active_at_reset_in;
   logic [udma_pkg::SRAM_WORDS_W-1:0]   sram_words_ff, sram_words_in;

   logic                                in_valid_ff, in_valid_in;
   udma_pkg::req_item_type              in_item_ff, in_item_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   udma_pkg::rsp_item_type              rsp_item_ff, rsp_item_in;

   udma_pkg::req_item_type              req_item;
   udma_pkg::rsp_item_type              step_result;
   logic                                advance;
   logic                                req_fire;

   // Configuration; the active reset value is the one this register takes under reset
   always_comb begin
      active_at_reset_in = active_at_reset_ff;
      sram_words_in      = sram_words_ff;
      if (reset) begin
         active_at_reset_in = udma_pkg::ACTIVE_AT_RESET_DEFAULT;
         sram_words_in      = udma_pkg::SRAM_WORDS_DEFAULT;
      end else if (csr_wen) begin
         case (csr_index)
            udma_pkg::CSR_ACTIVE_AT_RESET: active_at_reset_in = csr_wdata[0];
            udma_pkg::CSR_SRAM_WORDS:      sram_words_in      = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      active_at_reset_ff <= active_at_reset_in;
      sram_words_ff      <= sram_words_in;
   end

   assign req_item.cmd             = req_tuser[udma_pkg::CMD_W-1:0];
   assign req_item.reg_index       = req_tdata[2:0];
   assign req_item.write_value     = req_tdata[34:3];
   assign req_item.uart_word_valid = req_tdata[35];
   assign req_item.uart_word       = req_tdata[67:36];

   // Input register drains into the result register when that one is free or taken
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !reset && (!in_valid_ff || advance);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_item_in  = req_item;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = step_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_item_ff  <= in_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   udma_engine u_engine (
      .clock              (clock),
      .reset              (reset),
      .item_fire          (advance),
      .item               (in_item_ff),
      .active_reset_value (active_at_reset_in),
      .sram_words         (sram_words_ff),
      .result             (step_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0,
                        rsp_item_ff.status_now,
                        rsp_item_ff.irq_pending,
                        rsp_item_ff.store_data,
                        rsp_item_ff.store_address,
                        rsp_item_ff.store_valid,
                        rsp_item_ff.read_data};

endmodule

`default_nettype wire

@@ rtl/udma_checker.sv @@
// Port-level checks on the UART to SRAM DMA channel, bound to its top level.
// Depends on udma_pkg and the assertion macro header.
`default_nettype none

`include "uart_to_sram_dma_channel_assert.svh"

module udma_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [udma_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   logic                          store_valid;
   logic [udma_pkg::WORD_W-1:0]   store_address;
   logic [udma_pkg::WORD_W-1:0]   store_data;
   logic                          irq_pending;
   logic [udma_pkg::STATUS_W-1:0] status_now;
   logic                          rsp_stall;
   logic                          in_transfer;
   logic                          transfer_ended;
   logic                          store_quiet;

   assign store_valid   = rsp_tdata[32];
   assign store_address = rsp_tdata[64:33];
   assign store_data    = rsp_tdata[96:65];
   assign irq_pending   = rsp_tdata[97];
   assign status_now    = rsp_tdata[99:98];

   assign rsp_stall      = rsp_tvalid && !rsp_tready;
   assign in_transfer    = (status_now == udma_pkg::ST_BUSY)
                         || (status_now == udma_pkg::ST_COMPLETE);
   assign transfer_ended = (status_now == udma_pkg::ST_COMPLETE)
                         || (status_now == udma_pkg::ST_ERROR);
   assign store_quiet    = (store_address == '0) && (store_data == '0);

   `UDMA_ASSERT_ALWAYS(a_rsp_empty_after_reset, reset |=> !rsp_tvalid, "result after reset")

   `UDMA_ASSERT(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   `UDMA_ASSERT(a_store_in_transfer, rsp_tvalid && store_valid |-> in_transfer, "stray store")

   `UDMA_ASSERT(a_irq_needs_end, rsp_tvalid && irq_pending |-> transfer_ended, "stray interrupt")

   `UDMA_ASSERT(a_no_store_quiet, rsp_tvalid && !store_valid |-> store_quiet, "stray store fields")

endmodule

bind uart_to_sram_dma_channel udma_checker u_udma_checker (.*);

`default_nettype wire
